/* sv/sgr_pkg.sv */
// ============================================================================
// sgr_pkg - shared definitions for the slew guided requantizer
// Sizes, register indexes, sequencer states and small helper functions.
// ============================================================================
`default_nettype none

package sgr_pkg;

    // History storage
    localparam int HIST_DEPTH = 128;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    // Field widths
    localparam int SAMPLE_W   = 32;
    localparam int OUT_W      = 25;
    localparam int DIFF_W     = OUT_W + 1;
    localparam int SPAN_W     = 7;
    localparam int PROD_W     = DIFF_W + SPAN_W + 2;
    localparam int LHS_W      = PROD_W + 1;

    // Grid shifts: Q1.31 down to 2^15 or 2^23 steps per full scale
    localparam int SHIFT_LO   = SAMPLE_W - 1 - 15;
    localparam int SHIFT_HI   = SAMPLE_W - 1 - 23;

    // Span limits and reset value
    localparam logic [SPAN_W-1:0] SPAN_MIN   = SPAN_W'(3);
    localparam logic [SPAN_W-1:0] SPAN_MAX   = SPAN_W'(98);
    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(17);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPAN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = CFG_IDX_W'(1);

    typedef logic signed [OUT_W-1:0] hval_t;

    // One history word holds both channels
    typedef struct packed {
        hval_t left;
        hval_t right;
    } hist_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_COPY
    } seq_state_t;

    // Limit the span register to the supported range
    function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_W-1:0] span);
        logic [SPAN_W-1:0] res;
        res = span;
        if (span < SPAN_MIN)
            res = SPAN_MIN;
        else if (span > SPAN_MAX)
            res = SPAN_MAX;
        return res;
    endfunction

    // Floor onto the selected step grid (arithmetic shift right)
    function automatic hval_t requant_floor(input logic signed [SAMPLE_W-1:0] sample,
                                            input logic hi_res);
        logic signed [SAMPLE_W-1:0] sh;
        sh = hi_res ? (sample >>> SHIFT_HI) : (sample >>> SHIFT_LO);
        return hval_t'(sh[OUT_W-1:0]);
    endfunction

    // (a + b) mod len, valid while a + b < 2 * len
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b,
                                                   input logic [ADDR_W:0]   len);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= len)
            s = s - len;
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/slew_guided_requantizer_unit.sv */
// ============================================================================
// slew_guided_requantizer_unit - stereo Q1.31 to 16/24-bit requantizer
// Floors each channel onto the chosen grid and picks q or q+1 from the slew
// of that channel's output history, kept in a circular buffer in block RAM.
// ============================================================================
`default_nettype none

// Usage: an item passes stage 1, stage 2 and the output register in that
// order. A new stereo item can be taken while the previous one is still in
// stage 2, but it then waits in stage 1 until that one has left: the rate
// is set by the history feedback, since each result is the newest history
// entry that the next item's compare needs. The output register lets a new
// item enter while a result still waits downstream. After reset the history
// RAM is cleared entry by entry, during which in_stall is high. When the
// clamped span changes, the next item waits while the circular buffer is
// rewritten in home order into the other RAM bank, or while only the span is
// remapped when the buffer already sits at its home position. Configuration
// writes are always taken.

module slew_guided_requantizer_unit (
    input  wire                                        clk,
    input  wire                                        rst_n,
    // input items
    input  wire                                        in_valid,
    output logic                                       in_stall,
    input  wire  signed [sgr_pkg::SAMPLE_W-1:0]        left_sample,
    input  wire  signed [sgr_pkg::SAMPLE_W-1:0]        right_sample,
    // result items
    output logic                                       out_valid,
    input  wire                                        out_stall,
    output logic signed [sgr_pkg::OUT_W-1:0]           left_out,
    output logic signed [sgr_pkg::OUT_W-1:0]           right_out,
    // configuration writes
    input  wire                                        cfg_valid,
    output logic                                       cfg_ready,
    input  wire         [sgr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire         [sgr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = sgr_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    sgr_pkg::seq_state_t          state_reg, state_next;
    logic [AW-1:0]                cnt_reg, cnt_next;

    logic                         high_res_reg;
    logic [sgr_pkg::SPAN_W-1:0]   span_cfg_reg;
    logic [sgr_pkg::SPAN_W-1:0]   span_map_reg;
    logic [AW-1:0]                p_reg;
    logic                         sel_reg;

    sgr_pkg::hist_word_t          bank0_mem [sgr_pkg::HIST_DEPTH];
    sgr_pkg::hist_word_t          bank1_mem [sgr_pkg::HIST_DEPTH];
    sgr_pkg::hist_word_t          rd0_reg, rd1_reg;
    logic                         rd_bank_reg;

    logic                         copy_wr_valid_reg;
    logic [AW-1:0]                copy_wr_addr_reg;
    logic                         copy_wr_bank_reg;

    sgr_pkg::hist_word_t          last_reg;

    logic                         s1_valid_reg;
    sgr_pkg::hval_t               s1_q_l_reg, s1_q_r_reg;
    logic [AW-1:0]                s1_waddr_reg;

    logic                         s2_valid_reg;
    sgr_pkg::hval_t               s2_q_l_reg, s2_q_r_reg;
    logic signed [sgr_pkg::DIFF_W-1:0] s2_a_l_reg, s2_b_l_reg;
    logic signed [sgr_pkg::DIFF_W-1:0] s2_a_r_reg, s2_b_r_reg;
    logic [AW-1:0]                s2_waddr_reg;

    logic                         out_valid_reg;
    sgr_pkg::hval_t               out_l_reg, out_r_reg;

    logic [sgr_pkg::SPAN_W-1:0]   span_eff;
    logic [AW:0]                  span_len;
    logic                         span_ok;
    logic                         pipe_empty;
    logic                         s1_adv, s2_adv;
    logic                         in_ready, accept;
    logic [AW-1:0]                p_dec;
    logic [AW-1:0]                item_rd_addr;
    logic [AW-1:0]                copy_src;
    logic                         remap_idle;
    logic                         remap_start;
    logic                         span_fix;

    logic                         clear_we;
    logic                         copy_rd;
    logic                         seq_done;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    sgr_pkg::hist_word_t          rd_word;

    logic                         wr_en;
    logic                         wr_bank;
    logic [AW-1:0]                wr_addr;
    sgr_pkg::hist_word_t          wr_data;

    logic signed [sgr_pkg::DIFF_W-1:0] a_l, b_l, a_r, b_r;
    logic signed [sgr_pkg::SPAN_W+2:0] twice_span;
    logic signed [sgr_pkg::PROD_W-1:0] prod_l, prod_r;
    logic signed [sgr_pkg::LHS_W-1:0]  lhs_l, lhs_r, span_cmp;
    sgr_pkg::hval_t               res_l, res_r;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_res_reg <= 1'b0;
            span_cfg_reg <= sgr_pkg::SPAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sgr_pkg::CFG_HIGH_RES: high_res_reg <= cfg_data[0];
                sgr_pkg::CFG_SPAN:     span_cfg_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Span and circular buffer addressing
    // logical entry i < len lives at (p + i) mod len, the rest at i
    // ------------------------------------------------------------------
    assign span_eff     = sgr_pkg::clamp_span(span_cfg_reg);
    assign span_len     = {1'b0, span_map_reg} + (AW+1)'(2);
    assign span_ok      = (span_map_reg == span_eff);
    assign p_dec        = (p_reg == '0) ? AW'(span_len - (AW+1)'(1)) : p_reg - AW'(1);
    assign item_rd_addr = sgr_pkg::wrap_add(p_reg, span_map_reg, span_len);
    assign copy_src     = ({1'b0, cnt_reg} < span_len)
                          ? sgr_pkg::wrap_add(p_reg, cnt_reg, span_len) : cnt_reg;

    // ------------------------------------------------------------------
    // Pipeline flow
    // ------------------------------------------------------------------
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg;
    assign s2_adv     = s2_valid_reg && (!out_valid_reg || !out_stall);
    // newest history entry comes from stage 2, so wait until it has left
    assign s1_adv     = s1_valid_reg && !s2_valid_reg;
    assign in_ready   = (state_reg == sgr_pkg::ST_RUN) && !copy_wr_valid_reg && span_ok
                        && (!s1_valid_reg || s1_adv);
    assign in_stall   = !in_ready;
    assign accept     = in_valid && in_ready;

    assign remap_idle  = (state_reg == sgr_pkg::ST_RUN) && !span_ok && pipe_empty
                         && !copy_wr_valid_reg;
    assign remap_start = remap_idle && (p_reg != '0);
    assign span_fix    = remap_idle && (p_reg == '0);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            sgr_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(sgr_pkg::HIST_DEPTH - 1))
                    state_next = sgr_pkg::ST_RUN;
            end
            sgr_pkg::ST_RUN:
            begin
                if (remap_start)
                    state_next = sgr_pkg::ST_COPY;
            end
            sgr_pkg::ST_COPY:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(sgr_pkg::HIST_DEPTH - 1))
                    state_next = sgr_pkg::ST_RUN;
            end
            default:
            begin
                state_next = sgr_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        clear_we = 1'b0;
        copy_rd  = 1'b0;
        case (state_reg)
            sgr_pkg::ST_CLEAR: clear_we = 1'b1;
            sgr_pkg::ST_COPY:  copy_rd  = 1'b1;
            default:           ;
        endcase
        seq_done = (clear_we || copy_rd) && (cnt_reg == AW'(sgr_pkg::HIST_DEPTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgr_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Buffer pointer, mapped span and active bank
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg             <= '0;
            span_map_reg      <= sgr_pkg::SPAN_RESET;
            sel_reg           <= 1'b0;
            copy_wr_valid_reg <= 1'b0;
        end
        else
        begin
            copy_wr_valid_reg <= copy_rd;
            if (copy_rd && seq_done)
            begin
                // other bank now holds the history in home order
                sel_reg      <= !sel_reg;
                p_reg        <= '0;
                span_map_reg <= span_eff;
            end
            else
            begin
                if (span_fix)
                    span_map_reg <= span_eff;
                if (accept)
                    p_reg <= p_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_wr_addr_reg <= cnt_reg;
        copy_wr_bank_reg <= !sel_reg;
    end

    // ------------------------------------------------------------------
    // History RAM port muxes
    // ------------------------------------------------------------------
    assign rd_en   = accept || copy_rd;
    assign rd_addr = copy_rd ? copy_src : item_rd_addr;
    assign rd_word = rd_bank_reg ? rd1_reg : rd0_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_bank = sel_reg;
        wr_addr = s2_waddr_reg;
        wr_data = '{left: res_l, right: res_r};
        if (clear_we)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = '0;
        end
        else if (copy_wr_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_bank = copy_wr_bank_reg;
            wr_addr = copy_wr_addr_reg;
            wr_data = rd_word;
        end
        else if (s2_adv)
        begin
            wr_en = 1'b1;
        end
    end

    // Two banks, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
            bank0_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd0_reg <= bank0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_bank)
            bank1_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd1_reg <= bank1_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_bank_reg <= sel_reg;
    end

    // ------------------------------------------------------------------
    // Stage 1: floor onto grid, read oldest entry of the span
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_q_l_reg   <= sgr_pkg::requant_floor(left_sample, high_res_reg);
            s1_q_r_reg   <= sgr_pkg::requant_floor(right_sample, high_res_reg);
            s1_waddr_reg <= p_dec;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: differences against the newest entry
    // ------------------------------------------------------------------
    assign a_l = sgr_pkg::DIFF_W'(last_reg.left)  - sgr_pkg::DIFF_W'(s1_q_l_reg);
    assign b_l = sgr_pkg::DIFF_W'(rd_word.left)   - sgr_pkg::DIFF_W'(last_reg.left);
    assign a_r = sgr_pkg::DIFF_W'(last_reg.right) - sgr_pkg::DIFF_W'(s1_q_r_reg);
    assign b_r = sgr_pkg::DIFF_W'(rd_word.right)  - sgr_pkg::DIFF_W'(last_reg.right);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= 1'b1;
        else if (s2_adv)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_q_l_reg   <= s1_q_l_reg;
            s2_q_r_reg   <= s1_q_r_reg;
            s2_a_l_reg   <= a_l;
            s2_b_l_reg   <= b_l;
            s2_a_r_reg   <= a_r;
            s2_b_r_reg   <= b_r;
            s2_waddr_reg <= s1_waddr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Decision: keep q when 2*D*(h0-q) - 2*(hD-h0) < D
    // ------------------------------------------------------------------
    assign twice_span = $signed({2'b00, span_map_reg, 1'b0});
    assign span_cmp   = $signed({{(sgr_pkg::LHS_W - sgr_pkg::SPAN_W){1'b0}}, span_map_reg});
    assign prod_l     = sgr_pkg::PROD_W'(s2_a_l_reg) * sgr_pkg::PROD_W'(twice_span);
    assign prod_r     = sgr_pkg::PROD_W'(s2_a_r_reg) * sgr_pkg::PROD_W'(twice_span);
    assign lhs_l      = sgr_pkg::LHS_W'(prod_l) - (sgr_pkg::LHS_W'(s2_b_l_reg) <<< 1);
    assign lhs_r      = sgr_pkg::LHS_W'(prod_r) - (sgr_pkg::LHS_W'(s2_b_r_reg) <<< 1);
    assign res_l      = (lhs_l < span_cmp) ? s2_q_l_reg : s2_q_l_reg + sgr_pkg::hval_t'(1);
    assign res_r      = (lhs_r < span_cmp) ? s2_q_r_reg : s2_q_r_reg + sgr_pkg::hval_t'(1);

    // newest history entry, kept beside the RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else if (s2_adv)
            last_reg <= '{left: res_l, right: res_r};
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_l_reg <= res_l;
            out_r_reg <= res_r;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // history is only updated by items while the sequencer is running
    a_item_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv |-> (state_reg == sgr_pkg::ST_RUN))
        else $error("item write-back outside run state");

    // buffer pointer stays inside the rotating window
    a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, p_reg} < span_len))
        else $error("history pointer outside window");

    // a fresh result always comes out of stage 2
    a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result shown without stage 2 item");

    // copy writes only follow copy reads
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        copy_wr_valid_reg |-> $past(state_reg == sgr_pkg::ST_COPY))
        else $error("copy write without copy read");

endmodule

`default_nettype wire

/* dv/slew_guided_requantizer_unit_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// slew_guided_requantizer_unit_tb - self-checking bench for the requantizer
// Drives stereo Q1.31 item streams through the block under random bursts and
// output back-pressure, rewrites the grid and span registers between phases,
// and checks every result against an in-bench model of the per-channel
// history and the q / q+1 slew decision, or against a typed directed value.
// ============================================================================

module slew_guided_requantizer_unit_tb;

    // Bench constants
    localparam int          GRID_SHIFT_16 = 16;
    localparam int          GRID_SHIFT_24 = 8;
    localparam int          SPAN_LO       = 3;
    localparam int          SPAN_HI       = 98;
    localparam int          NUM_DIR       = 21;
    localparam int          RAND_ITEMS    = 1800;
    localparam int          LONG_HOLD     = 120;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  SPARE_IDX_A   = 2'd2;
    localparam logic [1:0]  SPARE_IDX_B   = 2'd3;

    // register indexes, short names for the stimulus table
    localparam logic [sgr_pkg::CFG_IDX_W-1:0] IDX_GRID = sgr_pkg::CFG_HIGH_RES;
    localparam logic [sgr_pkg::CFG_IDX_W-1:0] IDX_SPAN = sgr_pkg::CFG_SPAN;

    typedef struct packed {
        sgr_pkg::hval_t left;
        sgr_pkg::hval_t right;
    } out_pair_t;

    typedef struct packed {
        logic                            cfg_en;
        logic [sgr_pkg::CFG_IDX_W-1:0]   idx;
        logic [sgr_pkg::CFG_DATA_W-1:0]  data;
        logic [sgr_pkg::SAMPLE_W-1:0]    l;
        logic [sgr_pkg::SAMPLE_W-1:0]    r;
        logic                            typed;
        sgr_pkg::hval_t                  tl;
        sgr_pkg::hval_t                  tr;
    } dir_row_t;

    // DUT signals
    logic                                   clk;
    logic                                   rst_n        = 1'b0;
    logic                                   in_valid     = 1'b0;
    logic                                   in_stall;
    logic signed [sgr_pkg::SAMPLE_W-1:0]    left_sample  = '0;
    logic signed [sgr_pkg::SAMPLE_W-1:0]    right_sample = '0;
    logic                                   out_valid;
    logic                                   out_stall    = 1'b0;
    logic signed [sgr_pkg::OUT_W-1:0]       left_out;
    logic signed [sgr_pkg::OUT_W-1:0]       right_out;
    logic                                   cfg_valid    = 1'b0;
    logic                                   cfg_ready;
    logic [sgr_pkg::CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [sgr_pkg::CFG_DATA_W-1:0]         cfg_data     = '0;

    // Model state
    sgr_pkg::hval_t               hist_mem [2][sgr_pkg::HIST_DEPTH];
    logic                         grid_hi  = 1'b0;
    logic [sgr_pkg::SPAN_W-1:0]   span_reg = 7'd17;
    longint                       walk_pos [2];
    out_pair_t                    expected_pairs [$];

    // Bookkeeping
    int unsigned            cycle_count   = 0;
    int unsigned            items_sent    = 0;
    int unsigned            results_seen  = 0;
    int unsigned            mismatches    = 0;
    int unsigned            phases_run    = 0;
    int unsigned            holds_done    = 0;
    int unsigned            hi_items      = 0;
    bit                     hold_req      = 1'b0;

    dir_row_t               dir_rows [NUM_DIR];

    slew_guided_requantizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_pairs.size());
            $display("slew_guided_requantizer_unit_tb: errors");
            $finish;
        end
    end

    // One channel: floor onto the grid, pick q or q+1 from the slew, push
    function automatic sgr_pkg::hval_t step_channel(input int ch,
                                                    input logic signed [31:0] smp,
                                                    input int span);
        longint          q;
        longint          h0;
        longint          hd;
        longint          lhs;
        sgr_pkg::hval_t  res;
        int              i;
        q   = longint'(smp) >>> (grid_hi ? GRID_SHIFT_24 : GRID_SHIFT_16);
        h0  = longint'(hist_mem[ch][0]);
        hd  = longint'(hist_mem[ch][span]);
        lhs = 2 * longint'(span) * (h0 - q) - 2 * (hd - h0);
        res = (lhs < longint'(span)) ? sgr_pkg::hval_t'(q) : sgr_pkg::hval_t'(q + 1);
        // only entries up to span+1 move; deeper ones keep stale values
        for (i = span + 1; i >= 1; i--)
            hist_mem[ch][i] = hist_mem[ch][i - 1];
        hist_mem[ch][0] = res;
        return res;
    endfunction

    function automatic out_pair_t predict_pair(input logic [31:0] l, input logic [31:0] r);
        out_pair_t p;
        int        span;
        span = int'(span_reg);
        if (span < SPAN_LO)
            span = SPAN_LO;
        if (span > SPAN_HI)
            span = SPAN_HI;
        p.left  = step_channel(0, l, span);
        p.right = step_channel(1, r, span);
        return p;
    endfunction

    // Random sample: mostly slow walks, some full range, tiny and edge values
    function automatic logic [31:0] next_sample(input int ch);
        int unsigned roll;
        int unsigned k;
        longint      v;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            k = $urandom_range(4, 21);
            v = walk_pos[ch] + longint'($urandom_range(0, 1 << k)) - longint'(1 << (k - 1));
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            walk_pos[ch] = v;
            return v[31:0];
        end
        else if (roll < 80)
            return $urandom;
        else if (roll < 90)
            return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
        else
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0000_FFFF;
                default: return 32'hFFFF_0000;
            endcase
        end
    endfunction

    // Offer one item, hold it until taken, then queue its expected result
    task automatic send_item(input logic [31:0] l, input logic [31:0] r,
                             input logic typed, input sgr_pkg::hval_t tl,
                             input sgr_pkg::hval_t tr);
        out_pair_t p;
        in_valid     <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = predict_pair(l, r);
        if (typed)
        begin
            p.left  = tl;
            p.right = tr;
        end
        expected_pairs.push_back(p);
        items_sent++;
        if (grid_hi)
            hi_items++;
    endtask

    task automatic idle_gap(input int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every result, then let the pipe settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sgr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sgr_pkg::CFG_HIGH_RES: grid_hi  = data[0];
            sgr_pkg::CFG_SPAN:     span_reg = data;
            default:               ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input sgr_pkg::hval_t want,
                                   input sgr_pkg::hval_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        out_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_pairs.size() == 0)
                report_mismatch("result with nothing pending", '0, left_out);
            else
            begin
                want = expected_pairs.pop_front();
                if (left_out !== want.left)
                    report_mismatch("left_out", want.left, left_out);
                if (right_out !== want.right)
                    report_mismatch("right_out", want.right, right_out);
            end
        end
    end

    // Receiver: stall pattern in segments, plus a long hold on request
    initial
    begin : receiver
        int unsigned seg_len;
        int unsigned mode;
        int unsigned k;
        forever
        begin
            seg_len = $urandom_range(20, 200);
            mode    = $urandom_range(0, 3);
            for (k = 0; k < seg_len && !hold_req; k++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 70);
                    default: out_stall <= ((k % 4) == 3);
                endcase
            end
            if (hold_req)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned i;
        int unsigned k;
        int unsigned phase_len;
        int unsigned burst_left;
        bit          no_gaps;
        logic [6:0]  span_pick;

        for (i = 0; i < sgr_pkg::HIST_DEPTH; i++)
        begin
            hist_mem[0][i] = '0;
            hist_mem[1][i] = '0;
        end
        walk_pos[0] = 0;
        walk_pos[1] = 0;

        // directed rows: after reset, extremes, tiny values, span limits,
        // spare register indexes, and only bit 0 of the grid register counting
        dir_rows = '{
            '{1'b0, IDX_GRID,    7'd0,   32'h0000_0000, 32'h0000_0000, 1'b1,  25'sd0,     25'sd0},
            '{1'b0, IDX_GRID,    7'd0,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1,  25'sd32767, -25'sd32767},
            '{1'b0, IDX_GRID,    7'd0,   32'h8000_0000, 32'h7FFF_FFFF, 1'b1, -25'sd32767, 25'sd32767},
            '{1'b0, IDX_GRID,    7'd0,   32'h0000_0001, 32'hFFFF_FFFF, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_GRID,    7'd0,   32'h0000_FFFF, 32'h0001_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_GRID,    7'd0,   32'hFFFF_0000, 32'hFFFE_FFFF, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_GRID,    7'd1,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_GRID,    7'd0,   32'h0000_00FF, 32'hFFFF_FF00, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_GRID,    7'd0,   32'h0000_0100, 32'hFFFF_FEFF, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_SPAN,    7'd0,   32'hAAAA_AAAA, 32'h5555_5555, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_SPAN,    7'd2,   32'h1234_5678, 32'hEDCB_A987, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_SPAN,    7'd127, 32'h7FFF_FF00, 32'h8000_0100, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_SPAN,    7'd0,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_SPAN,    7'd98,  32'h0000_0000, 32'h0000_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_SPAN,    7'd3,   32'h4000_0000, 32'hC000_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_SPAN,    7'd0,   32'h4000_0080, 32'hBFFF_FF80, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, SPARE_IDX_A, 7'h7F,  32'h0100_0000, 32'hFF00_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, SPARE_IDX_B, 7'h55,  32'h0080_0000, 32'hFF80_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_GRID,    7'h7E,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0,  25'sd0,     25'sd0},
            '{1'b1, IDX_SPAN,    7'd17,  32'h0000_8000, 32'hFFFF_8000, 1'b0,  25'sd0,     25'sd0},
            '{1'b0, IDX_SPAN,    7'd0,   32'h0000_7FFF, 32'hFFFF_7FFF, 1'b0,  25'sd0,     25'sd0}
        };

        // reset once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (i = 0; i < NUM_DIR; i++)
        begin
            if (dir_rows[i].cfg_en)
            begin
                settle_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            send_item(dir_rows[i].l, dir_rows[i].r, dir_rows[i].typed,
                      dir_rows[i].tl, dir_rows[i].tr);
            idle_gap($urandom_range(0, 3));
        end

        // random phases, each with a fresh register setting
        while (items_sent < NUM_DIR + RAND_ITEMS)
        begin
            settle_idle();
            case ($urandom_range(0, 8))
                0:       span_pick = 7'd0;
                1:       span_pick = 7'd2;
                2:       span_pick = 7'd3;
                3:       span_pick = 7'd98;
                4:       span_pick = 7'd99;
                5:       span_pick = 7'd127;
                default: span_pick = 7'($urandom_range(0, 127));
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(sgr_pkg::CFG_SPAN, span_pick);
                write_reg(sgr_pkg::CFG_HIGH_RES, 7'($urandom));
            end
            else
            begin
                write_reg(sgr_pkg::CFG_HIGH_RES, 7'($urandom));
                write_reg(sgr_pkg::CFG_SPAN, span_pick);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? SPARE_IDX_A : SPARE_IDX_B, 7'($urandom));

            phase_len  = $urandom_range(60, 200);
            no_gaps    = ($urandom_range(0, 3) == 0);
            // phase 1: long output hold while input keeps coming
            if (phases_run == 1)
            begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
            end
            burst_left = $urandom_range(1, 40);
            for (k = 0; k < phase_len; k++)
            begin
                // phase 3: sender pauses mid-phase until the block drains
                if (phases_run == 3 && k == phase_len / 2)
                    settle_idle();
                send_item(next_sample(0), next_sample(1), 1'b0, '0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    if (!no_gaps)
                        idle_gap($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 40);
                end
            end
            phases_run++;
        end

        settle_idle();

        $display("covered %0d stereo items (%0d on the 24-bit grid) in %0d random phases,",
                 items_sent, hi_items, phases_run);
        $display("%0d results checked, %0d long output holds, %0d cycles",
                 results_seen, holds_done, cycle_count);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("slew_guided_requantizer_unit_tb: clean");
        else
            $display("slew_guided_requantizer_unit_tb: errors");
        $finish;
    end

endmodule
